@@ rtl/core/md5_pkg.sv @@
// ----------------------------------------------------------------------------
// MD5 message digest package
// Shared types, round constants and helper functions for the MD5 unit.
// ----------------------------------------------------------------------------
package md5_pkg;

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hefcdab89;
    localparam logic [31:0] INIT_C = 32'h98badcfe;
    localparam logic [31:0] INIT_D = 32'h10325476;

    localparam logic [7:0]  PAD_BYTE      = 8'h80;
    localparam int unsigned ROUNDS        = 64;
    localparam int unsigned BLOCK_WORDS   = 16;
    localparam logic [3:0]  LEN_LO_WORD   = 4'd14;
    localparam logic [3:0]  LEN_HI_WORD   = 4'd15;
    localparam logic [5:0]  CARRY_STD     = 6'd55;
    localparam logic [5:0]  CARRY_COMPAT  = 6'd56;
    localparam logic [5:0]  LAST_ROUND    = 6'(ROUNDS - 1);
    localparam logic [1:0]  LAST_DIGEST   = 2'd3;

    localparam logic [31:0] K_TABLE [ROUNDS] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] ROT_TABLE [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_ROUND,
        ST_UPDATE,
        ST_PAD_SEL,
        ST_OUT
    } md5_state_t;

    typedef enum logic [1:0] {
        BLK_DATA,
        BLK_PAD_ONLY,
        BLK_PAD_LEN,
        BLK_LEN_ONLY
    } blk_kind_t;

    typedef struct packed {
        logic       accept;
        logic       load_work;
        logic       do_round;
        logic [5:0] round_idx;
        logic [5:0] kw_idx;
        blk_kind_t  kind;
        logic       update;
        logic       finish;
        logic [1:0] out_idx;
    } md5_cmd_t;

    typedef struct packed {
        logic compress_due;
        logic two_blocks;
    } md5_status_t;

    function automatic logic [3:0] md5_g(input logic [5:0] idx);
        logic [3:0] lo;
        logic [3:0] res;
        lo = idx[3:0];
        case (idx[5:4])
            2'd0:    res = lo;
            2'd1:    res = 4'(5 * lo + 1);
            2'd2:    res = 4'(3 * lo + 5);
            default: res = 4'(7 * lo);
        endcase
        return res;
    endfunction

    function automatic logic [31:0] md5_rotl(input logic [31:0] x, input logic [4:0] s);
        logic [63:0] t;
        t = {x, x} << s;
        return t[63:32];
    endfunction

endpackage

@@ rtl/core/md5_datapath.sv @@
// ----------------------------------------------------------------------------
// MD5 datapath
// Block buffer, byte counter, chaining words, round registers and padding.
// ----------------------------------------------------------------------------
module md5_datapath
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  md5_pkg::md5_cmd_t    cmd,
    input  logic                 compat_mode,
    input  logic [31:0]          data_word,
    input  logic [2:0]           bytes_valid,
    input  logic                 last_item,
    output md5_pkg::md5_status_t status,
    output logic [31:0]          digest_word
);

    logic [31:0] blkbuf_reg [md5_pkg::BLOCK_WORDS];
    logic [28:0] count_reg;
    logic [28:0] count_next;
    logic [31:0] chain_reg [4];
    logic [31:0] work_reg [4];
    logic [31:0] kw_reg;
    logic [31:0] kw_next;

    logic [2:0]  nbytes;
    logic [31:0] keep;
    logic [3:0]  widx;
    logic [3:0]  g;
    logic [5:0]  remain;
    logic        hit_word;
    logic        in_data;
    logic [31:0] word_sel;
    logic [31:0] bit_len;
    logic [31:0] f_val;
    logic [31:0] sum_val;
    logic [31:0] new_b;
    logic [4:0]  rot;

    always_comb
    begin
        if (!last_item)
        begin
            nbytes = 3'd4;
        end
        else if (bytes_valid > 3'd4)
        begin
            nbytes = 3'd4;
        end
        else
        begin
            nbytes = bytes_valid;
        end
        case (nbytes)
            3'd0:    keep = 32'h0000_0000;
            3'd1:    keep = 32'h0000_00ff;
            3'd2:    keep = 32'h0000_ffff;
            3'd3:    keep = 32'h00ff_ffff;
            default: keep = 32'hffff_ffff;
        endcase
        widx       = count_reg[5:2];
        count_next = count_reg + 29'(nbytes);
    end

    assign status.compress_due = (nbytes != 3'd0) && (count_next[5:0] == 6'd0);
    assign remain              = count_reg[5:0];
    assign status.two_blocks   = compat_mode ? (remain > md5_pkg::CARRY_COMPAT)
                                             : (remain > md5_pkg::CARRY_STD);
    assign bit_len             = {count_reg, 3'b000};

    // Message word for the round being prefetched, with padding applied.
    always_comb
    begin
        g        = md5_pkg::md5_g(cmd.kw_idx);
        hit_word = (g == remain[5:2]);
        in_data  = (g < remain[5:2]) || (hit_word && (remain[1:0] != 2'd0));
        word_sel = 32'h0;
        case (cmd.kind) inside
            md5_pkg::BLK_DATA:
            begin
                word_sel = blkbuf_reg[g];
            end
            md5_pkg::BLK_PAD_ONLY, md5_pkg::BLK_PAD_LEN:
            begin
                if (in_data)
                begin
                    word_sel = blkbuf_reg[g];
                end
                if (hit_word)
                begin
                    word_sel = word_sel
                             | ({24'h0, md5_pkg::PAD_BYTE} << {remain[1:0], 3'b000});
                end
            end
            default:
            begin
                word_sel = 32'h0;
            end
        endcase
        if ((cmd.kind == md5_pkg::BLK_PAD_LEN) || (cmd.kind == md5_pkg::BLK_LEN_ONLY))
        begin
            if (g == md5_pkg::LEN_LO_WORD)
            begin
                word_sel = bit_len;
            end
            else if (g == md5_pkg::LEN_HI_WORD)
            begin
                word_sel = 32'h0;
            end
        end
        kw_next = md5_pkg::K_TABLE[cmd.kw_idx] + word_sel;
    end

    always_comb
    begin
        case (cmd.round_idx[5:4])
            2'd0:    f_val = (work_reg[1] & work_reg[2]) | (~work_reg[1] & work_reg[3]);
            2'd1:    f_val = (work_reg[1] & work_reg[3]) | (work_reg[2] & ~work_reg[3]);
            2'd2:    f_val = work_reg[1] ^ work_reg[2] ^ work_reg[3];
            default: f_val = work_reg[2] ^ (work_reg[1] | ~work_reg[3]);
        endcase
        rot     = md5_pkg::ROT_TABLE[{cmd.round_idx[5:4], cmd.round_idx[1:0]}];
        sum_val = work_reg[0] + f_val + kw_reg;
        new_b   = work_reg[1] + md5_pkg::md5_rotl(sum_val, rot);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && (nbytes != 3'd0))
        begin
            blkbuf_reg[widx] <= data_word & keep;
        end
        if (cmd.load_work || cmd.do_round)
        begin
            kw_reg <= kw_next;
        end
        if (cmd.load_work)
        begin
            work_reg <= chain_reg;
        end
        else if (cmd.do_round)
        begin
            work_reg[0] <= work_reg[3];
            work_reg[1] <= new_b;
            work_reg[2] <= work_reg[1];
            work_reg[3] <= work_reg[2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            chain_reg[0] <= md5_pkg::INIT_A;
            chain_reg[1] <= md5_pkg::INIT_B;
            chain_reg[2] <= md5_pkg::INIT_C;
            chain_reg[3] <= md5_pkg::INIT_D;
        end
        else if (cmd.finish)
        begin
            count_reg    <= '0;
            chain_reg[0] <= md5_pkg::INIT_A;
            chain_reg[1] <= md5_pkg::INIT_B;
            chain_reg[2] <= md5_pkg::INIT_C;
            chain_reg[3] <= md5_pkg::INIT_D;
        end
        else
        begin
            if (cmd.accept)
            begin
                count_reg <= count_next;
            end
            if (cmd.update)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    chain_reg[i] <= chain_reg[i] + work_reg[i];
                end
            end
        end
    end

    assign digest_word = chain_reg[cmd.out_idx];

endmodule

@@ rtl/core/md5_ctrl.sv @@
// ----------------------------------------------------------------------------
// MD5 controller
// Sequences word intake, compressions, final padding and digest output.
// ----------------------------------------------------------------------------
module md5_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 msg_valid,
    input  logic                 last_item,
    input  logic                 dig_stall,
    input  md5_pkg::md5_status_t status,
    output logic                 msg_stall,
    output logic                 dig_valid,
    output logic [1:0]           word_index,
    output logic                 last_word,
    output md5_pkg::md5_cmd_t    cmd
);

    md5_pkg::md5_state_t state_reg;
    md5_pkg::md5_state_t state_next;
    md5_pkg::blk_kind_t  kind_reg;
    md5_pkg::blk_kind_t  kind_next;
    logic [5:0]          round_reg;
    logic [5:0]          round_next;
    logic                last_pend_reg;
    logic                last_pend_next;
    logic [1:0]          out_idx_reg;
    logic [1:0]          out_idx_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= md5_pkg::ST_IDLE;
            kind_reg      <= md5_pkg::BLK_DATA;
            round_reg     <= '0;
            last_pend_reg <= 1'b0;
            out_idx_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            round_reg     <= round_next;
            last_pend_reg <= last_pend_next;
            out_idx_reg   <= out_idx_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        round_next     = round_reg;
        last_pend_next = last_pend_reg;
        out_idx_next   = out_idx_reg;
        unique case (state_reg)
            md5_pkg::ST_IDLE:
            begin
                if (msg_valid)
                begin
                    if (status.compress_due)
                    begin
                        state_next     = md5_pkg::ST_PREP;
                        kind_next      = md5_pkg::BLK_DATA;
                        last_pend_next = last_item;
                    end
                    else if (last_item)
                    begin
                        state_next = md5_pkg::ST_PAD_SEL;
                    end
                end
            end
            md5_pkg::ST_PREP:
            begin
                state_next = md5_pkg::ST_ROUND;
                round_next = '0;
            end
            md5_pkg::ST_ROUND:
            begin
                round_next = round_reg + 6'd1;
                if (round_reg == md5_pkg::LAST_ROUND)
                begin
                    state_next = md5_pkg::ST_UPDATE;
                end
            end
            md5_pkg::ST_UPDATE:
            begin
                unique case (kind_reg)
                    md5_pkg::BLK_DATA:
                    begin
                        state_next = last_pend_reg ? md5_pkg::ST_PAD_SEL : md5_pkg::ST_IDLE;
                    end
                    md5_pkg::BLK_PAD_ONLY:
                    begin
                        state_next = md5_pkg::ST_PREP;
                        kind_next  = md5_pkg::BLK_LEN_ONLY;
                    end
                    default:
                    begin
                        state_next   = md5_pkg::ST_OUT;
                        out_idx_next = '0;
                    end
                endcase
            end
            md5_pkg::ST_PAD_SEL:
            begin
                state_next = md5_pkg::ST_PREP;
                kind_next  = status.two_blocks ? md5_pkg::BLK_PAD_ONLY : md5_pkg::BLK_PAD_LEN;
            end
            md5_pkg::ST_OUT:
            begin
                if (!dig_stall)
                begin
                    out_idx_next = out_idx_reg + 2'd1;
                    if (out_idx_reg == md5_pkg::LAST_DIGEST)
                    begin
                        state_next = md5_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = md5_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        msg_stall     = (state_reg != md5_pkg::ST_IDLE);
        dig_valid     = (state_reg == md5_pkg::ST_OUT);
        word_index    = out_idx_reg;
        last_word     = (out_idx_reg == md5_pkg::LAST_DIGEST);
        cmd.accept    = (state_reg == md5_pkg::ST_IDLE) && msg_valid;
        cmd.load_work = (state_reg == md5_pkg::ST_PREP);
        cmd.do_round  = (state_reg == md5_pkg::ST_ROUND);
        cmd.round_idx = round_reg;
        cmd.kw_idx    = (state_reg == md5_pkg::ST_ROUND) ? (round_reg + 6'd1) : 6'd0;
        cmd.kind      = kind_reg;
        cmd.update    = (state_reg == md5_pkg::ST_UPDATE);
        cmd.finish    = (state_reg == md5_pkg::ST_OUT) && !dig_stall
                      && (out_idx_reg == md5_pkg::LAST_DIGEST);
        cmd.out_idx   = out_idx_reg;
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n) dig_valid |-> msg_stall)
        else $error("message transfer possible while digest is pending");

    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(dig_valid) |-> $past(last_word && !dig_stall))
        else $error("digest output ended before the final word transfer");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == md5_pkg::ST_PREP) |=>
            ((state_reg == md5_pkg::ST_ROUND) && (round_reg == 6'd0)))
        else $error("compression did not start at round zero");

    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == md5_pkg::ST_UPDATE) && (kind_reg == md5_pkg::BLK_PAD_ONLY)) |=>
            ((state_reg == md5_pkg::ST_PREP) && (kind_reg == md5_pkg::BLK_LEN_ONLY)))
        else $error("carry block not followed by length block");
`endif

endmodule

@@ rtl/core/md5_message_digest_unit.sv @@
// ----------------------------------------------------------------------------
// MD5 message digest unit
// Hashes a stream of little-endian message words and emits the 128-bit digest.
// ----------------------------------------------------------------------------
// A word that does not complete a 64-byte block is taken without a stall.
// A word that completes a block stalls the input while the block is compressed
// (load, 64 rounds of the single round unit, chaining add).
// A last word adds one or two padding compressions, plus a state to choose the
// padding, then four digest transfers.
// Reset restores the initial chaining values, clears the byte count and mode.
module md5_message_digest_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        msg_valid,
    output logic        msg_stall,
    input  logic [31:0] data_word,
    input  logic [2:0]  bytes_valid,
    input  logic        last_item,
    output logic        dig_valid,
    input  logic        dig_stall,
    output logic [31:0] digest_word,
    output logic [1:0]  word_index,
    output logic        last_word,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    md5_pkg::md5_cmd_t    cmd;
    md5_pkg::md5_status_t status;
    logic                 compat_reg;
    logic                 sel_compat;

    assign pready     = 1'b1;
    assign sel_compat = (paddr[2] == 1'b0);
    assign prdata     = sel_compat ? {31'h0, compat_reg} : 32'h0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            compat_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && pready && sel_compat)
        begin
            compat_reg <= pwdata[0];
        end
    end

    md5_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .msg_valid  (msg_valid),
        .last_item  (last_item),
        .dig_stall  (dig_stall),
        .status     (status),
        .msg_stall  (msg_stall),
        .dig_valid  (dig_valid),
        .word_index (word_index),
        .last_word  (last_word),
        .cmd        (cmd)
    );

    md5_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .compat_mode (compat_reg),
        .data_word   (data_word),
        .bytes_valid (bytes_valid),
        .last_item   (last_item),
        .status      (status),
        .digest_word (digest_word)
    );

endmodule
